### rtl/core/llc_pkg.sv
// Shared types, constants and the exp2 factor table for the LDR lux converter.
// Used by llc_ctrl, llc_dp and ldr_lux_converter; no other dependencies.
`default_nettype none

package llc_pkg;

    localparam int SPR_DEF      = 10;
    localparam int ADC_BITS_DEF = 12;

    localparam int IG_W      = 16;
    localparam int R0_W      = 24;
    localparam int RS_W      = 20;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;
    localparam int LUX_W     = 32;
    localparam int STAT_W    = 2;
    localparam int OUT_TW    = 40;

    localparam int FRAC_BITS = 24;
    localparam int EXP_SHIFT = 38;
    localparam int STEP_W    = 5;

    localparam logic [IG_W-1:0] IG_RST = 16'd17165;
    localparam logic [R0_W-1:0] R0_RST = 24'd2701500;
    localparam logic [RS_W-1:0] RS_RST = 20'd10000;

    localparam logic [CFG_IDX_W-1:0] CFG_INV_GAMMA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DARK_REF  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SERIES    = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_SAT   = 2'd2;

    // 12.0 in Q.38
    localparam logic [63:0] EXP_OFS = 64'd12 << EXP_SHIFT;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACC,
        OP_DIFF,
        OP_PROD,
        OP_LOAD_N,
        OP_LOAD_D,
        OP_NORM,
        OP_LOG_INIT,
        OP_SQUARE,
        OP_LG_DIFF,
        OP_GAMMA,
        OP_EXP_INIT,
        OP_EXP_STEP,
        OP_OUT_RESULT,
        OP_OUT_EMPTY,
        OP_OUT_SAT
    } t_dp_op;

    typedef struct packed {
        t_dp_op              op;
        logic [STEP_W-1:0]   step;
        logic                zero_out;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic den_zero;
        logic num_zero;
        logic norm_done;
        logic ip_neg;
        logic ip_big;
    } t_dp_stat;

    typedef logic [FRAC_BITS-1:0][31:0] t_fac_tab;

    // 2^(2^-(k+1)) in Q2.30, each the floor square root of the one before (the first of 2.0)
    function automatic t_fac_tab build_fac_tab();
        logic [63:0] c;
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        t_fac_tab    tab;
        c = 64'd1 << 31;
        for (int k = 0; k < FRAC_BITS; k++) begin
            v = c << 30;
            r = 64'd0;
            b = 64'd1 << 62;
            for (int j = 0; j < 32; j++) begin
                if (b > v) b = b >> 2;
            end
            for (int j = 0; j < 32; j++) begin
                if (b != 64'd0) begin
                    if (v >= r + b) begin
                        v = v - (r + b);
                        r = (r >> 1) + b;
                    end else begin
                        r = r >> 1;
                    end
                    b = b >> 2;
                end
            end
            c = r;
            tab[k] = c[31:0];
        end
        return tab;
    endfunction

    localparam t_fac_tab FAC_TAB = build_fac_tab();

endpackage

`default_nettype wire

### rtl/core/llc_dp.sv
// Datapath of the LDR lux converter: accumulator, products, log2 and exp2 units.
// Driven by llc_ctrl through llc_pkg::t_dp_cmd; uses llc_pkg constants and tables.
`default_nettype none

module llc_dp #(
    parameter int SPR      = llc_pkg::SPR_DEF,
    parameter int ADC_BITS = llc_pkg::ADC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [ADC_BITS-1:0]           i_sample,
    input  wire logic                          i_cfg_we,
    input  wire logic [llc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [llc_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire llc_pkg::t_dp_cmd              i_cmd,
    output      llc_pkg::t_dp_stat             o_stat,
    output      logic [llc_pkg::LUX_W-1:0]     o_lux,
    output      logic [llc_pkg::STAT_W-1:0]    o_status
);

    localparam int FS_I   = (1 << ADC_BITS) - 1;
    localparam int SUM_W  = $clog2(SPR * FS_I + 1);
    localparam int CNT_W  = $clog2(SPR + 1);
    localparam int NUM_W  = llc_pkg::R0_W + SUM_W;
    localparam int DEN_W  = llc_pkg::RS_W + SUM_W;
    localparam int P_W    = $clog2(NUM_W);
    localparam int FB     = llc_pkg::FRAC_BITS;
    localparam int LOGW   = P_W + FB;
    localparam int LGW    = LOGW + 1;
    localparam int T_W    = ((LGW + 17) > 45 ? (LGW + 17) : 45) + 1;
    localparam int ES     = llc_pkg::EXP_SHIFT;
    localparam logic [SUM_W-1:0] FS_S = SUM_W'(FS_I);

    logic [llc_pkg::IG_W-1:0] r_ig;
    logic [llc_pkg::R0_W-1:0] r_r0;
    logic [llc_pkg::RS_W-1:0] r_rs;

    logic [SUM_W-1:0]         r_sum;
    logic [CNT_W-1:0]         r_cnt;
    logic [SUM_W-1:0]         r_gsum;
    logic [SUM_W-1:0]         r_diff;
    logic                     r_empty;
    logic [NUM_W-1:0]         r_num;
    logic [DEN_W-1:0]         r_den;
    logic [NUM_W-1:0]         r_v;
    logic [P_W-1:0]           r_p;
    logic [31:0]              r_x;
    logic [LOGW-1:0]          r_lg;
    logic [LOGW-1:0]          r_ln;
    logic signed [LGW-1:0]    r_lgd;
    logic signed [T_W-1:0]    r_t;
    logic [31:0]              r_m;
    logic [FB-1:0]            r_f;
    logic [llc_pkg::LUX_W-1:0]  r_lux;
    logic [llc_pkg::STAT_W-1:0] r_status;

    logic [63:0]              sq;
    logic [32:0]              sq_y;
    logic [63:0]              mp;
    logic signed [T_W-1:0]    tprod;
    logic [4:0]               ip5;
    logic [4:0]               shamt;

    always_comb begin
        sq    = 64'(r_x) * 64'(r_x);
        sq_y  = sq[63:31];
        mp    = 64'(r_m) * 64'(llc_pkg::FAC_TAB[i_cmd.step]);
        tprod = T_W'(r_lgd) * T_W'(signed'({1'b0, r_ig}));
        ip5   = r_t[ES+4:ES];
        shamt = 5'd30 - ip5;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ig <= llc_pkg::IG_RST;
            r_r0 <= llc_pkg::R0_RST;
            r_rs <= llc_pkg::RS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                llc_pkg::CFG_INV_GAMMA: r_ig <= i_cfg_data[llc_pkg::IG_W-1:0];
                llc_pkg::CFG_DARK_REF:  r_r0 <= i_cfg_data[llc_pkg::R0_W-1:0];
                llc_pkg::CFG_SERIES:    r_rs <= i_cfg_data[llc_pkg::RS_W-1:0];
                default: ;
            endcase
        end
    end

    // group accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (i_cmd.op == llc_pkg::OP_ACC) begin
            if (i_sample != '0) begin
                r_sum <= r_sum + SUM_W'(i_sample);
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end else if (i_cmd.op == llc_pkg::OP_DIFF) begin
            r_sum <= '0;
            r_cnt <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            llc_pkg::OP_DIFF: begin
                r_gsum  <= r_sum;
                r_diff  <= SUM_W'(FS_S * SUM_W'(r_cnt)) - r_sum;
                r_empty <= (r_cnt == '0);
            end
            llc_pkg::OP_PROD: begin
                r_num <= NUM_W'(r_r0) * NUM_W'(r_gsum);
                r_den <= DEN_W'(r_rs) * DEN_W'(r_diff);
            end
            llc_pkg::OP_LOAD_N: begin
                r_v <= r_num;
                r_p <= P_W'(NUM_W - 1);
            end
            llc_pkg::OP_LOAD_D: begin
                r_v  <= NUM_W'(r_den);
                r_p  <= P_W'(NUM_W - 1);
                r_ln <= r_lg;
            end
            llc_pkg::OP_NORM: begin
                r_v <= r_v << 1;
                r_p <= r_p - P_W'(1);
            end
            llc_pkg::OP_LOG_INIT: begin
                r_x  <= r_v[NUM_W-1 -: 32];
                r_lg <= {r_p, {FB{1'b0}}};
            end
            llc_pkg::OP_SQUARE: begin
                r_x         <= sq_y[32] ? sq_y[32:1] : sq_y[31:0];
                r_lg[FB-1:0] <= {r_lg[FB-2:0], sq_y[32]};
            end
            llc_pkg::OP_LG_DIFF: begin
                r_lgd <= signed'({1'b0, r_ln}) - signed'({1'b0, r_lg});
            end
            llc_pkg::OP_GAMMA: begin
                r_t <= tprod + signed'(T_W'(llc_pkg::EXP_OFS));
            end
            llc_pkg::OP_EXP_INIT: begin
                r_m <= 32'd1 << 30;
                r_f <= r_t[ES-1 -: FB];
            end
            llc_pkg::OP_EXP_STEP: begin
                if (r_f[FB-1]) r_m <= mp[61:30];
                r_f <= r_f << 1;
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            llc_pkg::OP_OUT_EMPTY: begin
                r_lux    <= '0;
                r_status <= llc_pkg::ST_EMPTY;
            end
            llc_pkg::OP_OUT_SAT: begin
                r_lux    <= '1;
                r_status <= llc_pkg::ST_SAT;
            end
            llc_pkg::OP_OUT_RESULT: begin
                if (i_cmd.zero_out) begin
                    r_lux    <= '0;
                    r_status <= llc_pkg::ST_OK;
                end else if (ip5 == 5'd31) begin
                    if (r_m[31]) begin
                        r_lux    <= '1;
                        r_status <= llc_pkg::ST_SAT;
                    end else begin
                        r_lux    <= {r_m[30:0], 1'b0};
                        r_status <= llc_pkg::ST_OK;
                    end
                end else begin
                    r_lux    <= r_m >> shamt;
                    r_status <= llc_pkg::ST_OK;
                end
            end
            default: ;
        endcase
    end

    assign o_stat.empty     = r_empty;
    assign o_stat.den_zero  = (r_den == '0);
    assign o_stat.num_zero  = (r_num == '0);
    assign o_stat.norm_done = r_v[NUM_W-1];
    assign o_stat.ip_neg    = r_t[T_W-1];
    assign o_stat.ip_big    = !r_t[T_W-1] && (r_t[T_W-2:ES+5] != '0);
    assign o_lux            = r_lux;
    assign o_status         = r_status;

endmodule

`default_nettype wire

### rtl/core/llc_ctrl.sv
// Sequencer of the LDR lux converter: group counting, handshakes, datapath steps.
// Uses llc_pkg command and status types; drives llc_dp.
`default_nettype none

module llc_ctrl #(
    parameter int SPR = llc_pkg::SPR_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output      logic              o_s_tready,
    output      logic              o_m_tvalid,
    input  wire logic              i_m_tready,
    input  wire llc_pkg::t_dp_stat i_stat,
    output      llc_pkg::t_dp_cmd  o_cmd
);

    localparam int IDX_W = (SPR > 1) ? $clog2(SPR) : 1;
    localparam logic [llc_pkg::STEP_W-1:0] LAST_STEP =
        llc_pkg::STEP_W'(llc_pkg::FRAC_BITS - 1);

    typedef enum logic [3:0] {
        S_ACC, S_DIFF, S_PROD, S_CHECK, S_LOAD, S_NORM, S_SQ,
        S_LGDIFF, S_GAMMA, S_RANGE, S_EXP, S_FIN, S_OUT
    } t_state;

    t_state                     r_state, n_state;
    logic [IDX_W-1:0]           r_idx, n_idx;
    logic [llc_pkg::STEP_W-1:0] r_step, n_step;
    logic                       r_second, n_second;
    logic                       r_zero, n_zero;
    logic                       r_valid, n_valid;
    logic                       in_beat;

    assign in_beat = i_s_tvalid && (r_state == S_ACC);

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_step   = r_step;
        n_second = r_second;
        n_zero   = r_zero;
        n_valid  = r_valid;
        o_cmd.op       = llc_pkg::OP_NONE;
        o_cmd.step     = r_step;
        o_cmd.zero_out = r_zero;
        unique case (r_state)
            S_ACC: begin
                if (in_beat) begin
                    o_cmd.op = llc_pkg::OP_ACC;
                    if (r_idx == IDX_W'(SPR - 1)) begin
                        n_idx   = '0;
                        n_state = S_DIFF;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            S_DIFF: begin
                o_cmd.op = llc_pkg::OP_DIFF;
                n_state  = S_PROD;
            end
            S_PROD: begin
                o_cmd.op = llc_pkg::OP_PROD;
                n_state  = S_CHECK;
            end
            S_CHECK: begin
                n_second = 1'b0;
                n_zero   = 1'b0;
                if (i_stat.empty) begin
                    o_cmd.op = llc_pkg::OP_OUT_EMPTY;
                    n_valid  = 1'b1;
                    n_state  = S_OUT;
                end else if (i_stat.den_zero) begin
                    o_cmd.op = llc_pkg::OP_OUT_SAT;
                    n_valid  = 1'b1;
                    n_state  = S_OUT;
                end else if (i_stat.num_zero) begin
                    n_zero  = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.op = r_second ? llc_pkg::OP_LOAD_D : llc_pkg::OP_LOAD_N;
                n_state  = S_NORM;
            end
            S_NORM: begin
                // shift up until the leading one reaches the top bit
                if (i_stat.norm_done) begin
                    o_cmd.op = llc_pkg::OP_LOG_INIT;
                    n_step   = '0;
                    n_state  = S_SQ;
                end else begin
                    o_cmd.op = llc_pkg::OP_NORM;
                end
            end
            S_SQ: begin
                o_cmd.op = llc_pkg::OP_SQUARE;
                n_step   = r_step + llc_pkg::STEP_W'(1);
                if (r_step == LAST_STEP) begin
                    n_second = 1'b1;
                    n_state  = r_second ? S_LGDIFF : S_LOAD;
                end
            end
            S_LGDIFF: begin
                o_cmd.op = llc_pkg::OP_LG_DIFF;
                n_state  = S_GAMMA;
            end
            S_GAMMA: begin
                o_cmd.op = llc_pkg::OP_GAMMA;
                n_state  = S_RANGE;
            end
            S_RANGE: begin
                if (i_stat.ip_big) begin
                    o_cmd.op = llc_pkg::OP_OUT_SAT;
                    n_valid  = 1'b1;
                    n_state  = S_OUT;
                end else if (i_stat.ip_neg) begin
                    n_zero  = 1'b1;
                    n_state = S_FIN;
                end else begin
                    o_cmd.op = llc_pkg::OP_EXP_INIT;
                    n_step   = '0;
                    n_state  = S_EXP;
                end
            end
            S_EXP: begin
                o_cmd.op = llc_pkg::OP_EXP_STEP;
                n_step   = r_step + llc_pkg::STEP_W'(1);
                if (r_step == LAST_STEP) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.op = llc_pkg::OP_OUT_RESULT;
                n_valid  = 1'b1;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_m_tready) begin
                    n_valid = 1'b0;
                    n_state = S_ACC;
                end
            end
            default: n_state = S_ACC;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_ACC;
            r_idx    <= '0;
            r_step   <= '0;
            r_second <= 1'b0;
            r_zero   <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_step   <= n_step;
            r_second <= n_second;
            r_zero   <= n_zero;
            r_valid  <= n_valid;
        end
    end

    assign o_s_tready = (r_state == S_ACC);
    assign o_m_tvalid = r_valid;

endmodule

`default_nettype wire

### rtl/core/ldr_lux_converter.sv
// LDR lux converter top level. One beat per cycle is taken while collecting a group.
// After a group's last beat come the DIFF, PROD and CHECK states; for an empty group or
// zero resistance the result beat is valid after CHECK, else after two log2 passes (normalize up
// to 39 shifts, then 24 squarings in one 32x32 multiplier), one gamma multiply and 24
// exp2 multiply steps. Input is held off until the result beat is taken.
// Synchronous active-low reset clears all control state and loads register defaults.
`default_nettype none

module ldr_lux_converter #(
    parameter int SPR      = llc_pkg::SPR_DEF,
    parameter int ADC_BITS = llc_pkg::ADC_BITS_DEF,
    localparam int IN_TW   = ((ADC_BITS + 7) / 8) * 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output      logic                          o_s_tready,
    input  wire logic [IN_TW-1:0]              i_s_tdata,  // adc_sample
    output      logic                          o_m_tvalid,
    input  wire logic                          i_m_tready,
    output      logic [llc_pkg::OUT_TW-1:0]    o_m_tdata,  // lux_value, status
    input  wire logic                          i_cfg_we,
    input  wire logic [llc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [llc_pkg::CFG_W-1:0]     i_cfg_data
);

    llc_pkg::t_dp_cmd              cmd;
    llc_pkg::t_dp_stat             stat;
    logic [llc_pkg::LUX_W-1:0]     lux;
    logic [llc_pkg::STAT_W-1:0]    status;

    llc_ctrl #(.SPR(SPR)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    llc_dp #(.SPR(SPR), .ADC_BITS(ADC_BITS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (i_s_tdata[ADC_BITS-1:0]),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_lux      (lux),
        .o_status   (status)
    );

    assign o_m_tdata = {{(llc_pkg::OUT_TW - llc_pkg::LUX_W - llc_pkg::STAT_W){1'b0}},
                        status, lux};

endmodule

`default_nettype wire
